// ===== sv/tsw_pkg.sv =====
package tsw_pkg;

   // operation codes passed from the classifier to the execution side
   localparam logic [2:0] OP_CHAR      = 3'd0;
   localparam logic [2:0] OP_END_WORD  = 3'd1;
   localparam logic [2:0] OP_END_TEXT  = 3'd2;
   localparam logic [2:0] OP_LOAD_CHAR = 3'd3;
   localparam logic [2:0] OP_LOAD_END  = 3'd4;

   // input kind codes
   localparam logic [1:0] KIND_TEXT     = 2'd0;
   localparam logic [1:0] KIND_END_TEXT = 2'd1;
   localparam logic [1:0] KIND_STOP     = 2'd2;
   localparam logic [1:0] KIND_STOP_END = 2'd3;

   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_DASH   = 8'h2D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;

   localparam int unsigned POS_W = 16;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   typedef struct packed {
      logic [2:0] code;
      logic [7:0] chr;
   } op_type;

   // ascii lowercase
   function automatic logic [7:0] lower_ascii(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

// ===== sv/tsw_ram.sv =====
module tsw_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/tsw_front.sv =====
module tsw_front (
   input  logic                 req_valid,
   input  logic [1:0]           req_kind,
   input  logic [7:0]           req_data_byte,
   input  logic                 q_full,
   output logic                 req_stall,
   output logic                 push,
   output tsw_pkg::op_type      push_op
);

   logic is_space;
   logic is_kept;
   logic keep_item;

   // byte classes
   always_comb begin
      is_space = (req_data_byte == tsw_pkg::CHAR_SPACE) ||
                 (req_data_byte >= tsw_pkg::CHAR_TAB && req_data_byte <= tsw_pkg::CHAR_CR);
      is_kept  = (req_data_byte >= 8'h61 && req_data_byte <= 8'h7A) ||
                 (req_data_byte >= 8'h41 && req_data_byte <= 8'h5A) ||
                 (req_data_byte >= 8'h30 && req_data_byte <= 8'h39) ||
                 (req_data_byte == tsw_pkg::CHAR_DASH);
   end

   // map a transaction to an operation, dropped bytes push nothing
   always_comb begin
      push_op.chr  = tsw_pkg::lower_ascii(req_data_byte);
      push_op.code = tsw_pkg::OP_CHAR;
      keep_item    = 1'b1;
      case (req_kind)
         tsw_pkg::KIND_TEXT: begin
            if (is_space) begin
               push_op.code = tsw_pkg::OP_END_WORD;
            end else if (is_kept) begin
               push_op.code = tsw_pkg::OP_CHAR;
            end else begin
               keep_item = 1'b0;
            end
         end
         tsw_pkg::KIND_END_TEXT: push_op.code = tsw_pkg::OP_END_TEXT;
         tsw_pkg::KIND_STOP:     push_op.code = tsw_pkg::OP_LOAD_CHAR;
         tsw_pkg::KIND_STOP_END: push_op.code = tsw_pkg::OP_LOAD_END;
         default:                keep_item    = 1'b0;
      endcase
   end

   assign req_stall = q_full;
   assign push      = req_valid && !q_full && keep_item;

endmodule

// ===== sv/tsw_queue.sv =====
module tsw_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  tsw_pkg::op_type push_op,
   input  logic            pop,
   output logic            full,
   output logic            q_valid,
   output tsw_pkg::op_type q_op
);

   tsw_pkg::op_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_pop;

   assign do_pop  = pop && (cnt_ff != 2'd0);
   assign full    = (cnt_ff == 2'd2);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_op    = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

   assert property (@(posedge clock) disable iff (reset) full |-> !push)
      else $error("queue written while full");
   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count out of range");
   assert property (@(posedge clock) disable iff (reset)
      (push && !do_pop) |=> (cnt_ff == $past(cnt_ff) + 2'd1))
      else $error("queue count missed a push");

endmodule

// ===== sv/tsw_back.sv =====
module tsw_back #(
   parameter int unsigned MAX_WORD = 32,
   parameter int unsigned MAX_STOP = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  tsw_pkg::op_type              q_op,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_token_char,
   output logic [tsw_pkg::POS_W-1:0]    rsp_token_position,
   output logic                         rsp_last_char,
   output logic                         rsp_truncated
);

   localparam int unsigned LW   = $clog2(MAX_WORD + 1);
   localparam int unsigned AW   = $clog2(MAX_WORD);
   localparam int unsigned CW   = $clog2(MAX_STOP + 1);
   localparam int unsigned SAW  = (MAX_STOP > 1) ? $clog2(MAX_STOP) : 1;
   localparam int unsigned CDEP = MAX_STOP * MAX_WORD;
   localparam int unsigned CAW  = $clog2(CDEP);
   localparam int unsigned BW   = CAW + 1;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LEN   = 4'd1;
   localparam logic [3:0] S_LENW  = 4'd2;
   localparam logic [3:0] S_CH    = 4'd3;
   localparam logic [3:0] S_CHW   = 4'd4;
   localparam logic [3:0] S_EMIT  = 4'd5;
   localparam logic [3:0] S_EMITW = 4'd6;
   localparam logic [3:0] S_CP    = 4'd7;
   localparam logic [3:0] S_CPW   = 4'd8;

   logic [3:0]               state_ff, state_in;
   logic [LW-1:0]            word_len_ff, word_len_in;
   logic                     word_ovf_ff, word_ovf_in;
   logic [LW-1:0]            load_len_ff, load_len_in;
   logic                     load_ovf_ff, load_ovf_in;
   logic [7:0]               load_last_ff, load_last_in;
   logic [tsw_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [BW-1:0]            tail_ff, tail_in;
   logic [CW-1:0]            ent_ff, ent_in;
   logic [BW-1:0]            base_ff, base_in;
   logic [LW-1:0]            idx_ff, idx_in;
   logic [LW-1:0]            cmp_len_ff, cmp_len_in;
   logic                     src_load_ff, src_load_in;
   logic                     eot_ff, eot_in;
   logic                     out_valid_ff, out_valid_in;
   logic [7:0]               out_char_ff, out_char_in;
   logic [tsw_pkg::POS_W-1:0] out_pos_ff, out_pos_in;
   logic                     out_last_ff, out_last_in;
   logic                     out_trunc_ff, out_trunc_in;

   logic                     word_we, load_we, chars_we, lens_we;
   logic [7:0]               word_rd, load_rd, chars_rd, src_rd;
   logic [LW-1:0]            lens_rd;
   logic [BW-1:0]            rd_sum, wr_sum;
   logic [LW-1:0]            load_trim;
   logic                     slot_free;

   assign rd_sum    = base_ff + BW'(idx_ff);
   assign wr_sum    = tail_ff + BW'(idx_ff);
   assign src_rd    = src_load_ff ? load_rd : word_rd;
   assign slot_free = !out_valid_ff || !rsp_stall;
   assign pop       = (state_ff == S_IDLE) && q_valid;

   // stop entry length with a trailing carriage return removed
   always_comb begin
      load_trim = load_len_ff;
      if (!load_ovf_ff && load_len_ff != '0 && load_last_ff == tsw_pkg::CHAR_CR) begin
         load_trim = load_len_ff - LW'(1);
      end
   end

   // current word buffer
   tsw_ram #(.WIDTH(8), .DEPTH(MAX_WORD)) u_word (
      .clock(clock), .wr_en(word_we), .wr_addr(word_len_ff[AW-1:0]),
      .wr_data(q_op.chr), .rd_addr(idx_ff[AW-1:0]), .rd_data(word_rd)
   );

   // stop word being loaded
   tsw_ram #(.WIDTH(8), .DEPTH(MAX_WORD)) u_load (
      .clock(clock), .wr_en(load_we), .wr_addr(load_len_ff[AW-1:0]),
      .wr_data(q_op.chr), .rd_addr(idx_ff[AW-1:0]), .rd_data(load_rd)
   );

   // stop word characters, one row of MAX_WORD per entry
   tsw_ram #(.WIDTH(8), .DEPTH(CDEP)) u_chars (
      .clock(clock), .wr_en(chars_we), .wr_addr(wr_sum[CAW-1:0]),
      .wr_data(load_rd), .rd_addr(rd_sum[CAW-1:0]), .rd_data(chars_rd)
   );

   // stop word lengths
   tsw_ram #(.WIDTH(LW), .DEPTH(MAX_STOP)) u_lens (
      .clock(clock), .wr_en(lens_we), .wr_addr(count_ff[SAW-1:0]),
      .wr_data(cmp_len_ff), .rd_addr(ent_ff[SAW-1:0]), .rd_data(lens_rd)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      word_len_in  = word_len_ff;
      word_ovf_in  = word_ovf_ff;
      load_len_in  = load_len_ff;
      load_ovf_in  = load_ovf_ff;
      load_last_in = load_last_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      tail_in      = tail_ff;
      ent_in       = ent_ff;
      base_in      = base_ff;
      idx_in       = idx_ff;
      cmp_len_in   = cmp_len_ff;
      src_load_in  = src_load_ff;
      eot_in       = eot_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_char_in  = out_char_ff;
      out_pos_in   = out_pos_ff;
      out_last_in  = out_last_ff;
      out_trunc_in = out_trunc_ff;
      word_we      = 1'b0;
      load_we      = 1'b0;
      chars_we     = 1'b0;
      lens_we      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               case (q_op.code)
                  tsw_pkg::OP_CHAR: begin
                     if (word_len_ff != LW'(MAX_WORD)) begin
                        word_we     = 1'b1;
                        word_len_in = word_len_ff + LW'(1);
                     end else begin
                        word_ovf_in = 1'b1;
                     end
                  end
                  tsw_pkg::OP_END_WORD, tsw_pkg::OP_END_TEXT: begin
                     eot_in      = (q_op.code == tsw_pkg::OP_END_TEXT);
                     src_load_in = 1'b0;
                     cmp_len_in  = word_len_ff;
                     idx_in      = '0;
                     ent_in      = '0;
                     base_in     = '0;
                     if (word_len_ff == '0) begin
                        if (q_op.code == tsw_pkg::OP_END_TEXT) begin
                           pos_in = '0;
                        end
                     end else if (word_ovf_ff) begin
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_LEN;
                     end
                  end
                  tsw_pkg::OP_LOAD_CHAR: begin
                     if (load_len_ff != LW'(MAX_WORD)) begin
                        load_we      = 1'b1;
                        load_len_in  = load_len_ff + LW'(1);
                        load_last_in = q_op.chr;
                     end else begin
                        load_ovf_in = 1'b1;
                     end
                  end
                  tsw_pkg::OP_LOAD_END: begin
                     src_load_in = 1'b1;
                     cmp_len_in  = load_trim;
                     idx_in      = '0;
                     ent_in      = '0;
                     base_in     = '0;
                     if (load_ovf_ff || load_trim == '0 || count_ff == CW'(MAX_STOP)) begin
                        load_len_in = '0;
                        load_ovf_in = 1'b0;
                     end else begin
                        state_in = S_LEN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_LEN: begin
            if (ent_ff == count_ff) begin
               // no match in the table
               idx_in   = '0;
               state_in = src_load_ff ? S_CP : S_EMIT;
            end else begin
               state_in = S_LENW;
            end
         end
         S_LENW: begin
            idx_in = '0;
            if (lens_rd == cmp_len_ff) begin
               state_in = S_CH;
            end else begin
               ent_in   = ent_ff + CW'(1);
               base_in  = base_ff + BW'(MAX_WORD);
               state_in = S_LEN;
            end
         end
         S_CH: state_in = S_CHW;
         S_CHW: begin
            if (chars_rd != src_rd) begin
               ent_in   = ent_ff + CW'(1);
               base_in  = base_ff + BW'(MAX_WORD);
               state_in = S_LEN;
            end else if (idx_ff == cmp_len_ff - LW'(1)) begin
               // match: drop the word or the stop entry
               state_in = S_IDLE;
               if (src_load_ff) begin
                  load_len_in = '0;
                  load_ovf_in = 1'b0;
               end else begin
                  word_len_in = '0;
                  word_ovf_in = 1'b0;
                  if (eot_ff) begin
                     pos_in = '0;
                  end
               end
            end else begin
               idx_in   = idx_ff + LW'(1);
               state_in = S_CH;
            end
         end
         S_EMIT: state_in = S_EMITW;
         S_EMITW: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_char_in  = word_rd;
               out_pos_in   = pos_ff;
               out_last_in  = (idx_ff == word_len_ff - LW'(1));
               out_trunc_in = word_ovf_ff;
               if (idx_ff == word_len_ff - LW'(1)) begin
                  state_in    = S_IDLE;
                  word_len_in = '0;
                  word_ovf_in = 1'b0;
                  if (eot_ff) begin
                     pos_in = '0;
                  end else if (pos_ff != tsw_pkg::POS_MAX) begin
                     pos_in = pos_ff + {{(tsw_pkg::POS_W-1){1'b0}}, 1'b1};
                  end
               end else begin
                  idx_in   = idx_ff + LW'(1);
                  state_in = S_EMIT;
               end
            end
         end
         S_CP: state_in = S_CPW;
         S_CPW: begin
            chars_we = 1'b1;
            if (idx_ff == cmp_len_ff - LW'(1)) begin
               lens_we     = 1'b1;
               count_in    = count_ff + CW'(1);
               tail_in     = tail_ff + BW'(MAX_WORD);
               load_len_in = '0;
               load_ovf_in = 1'b0;
               state_in    = S_IDLE;
            end else begin
               idx_in   = idx_ff + LW'(1);
               state_in = S_CP;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         word_len_ff  <= '0;
         word_ovf_ff  <= 1'b0;
         load_len_ff  <= '0;
         load_ovf_ff  <= 1'b0;
         pos_ff       <= '0;
         count_ff     <= '0;
         tail_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_len_ff  <= word_len_in;
         word_ovf_ff  <= word_ovf_in;
         load_len_ff  <= load_len_in;
         load_ovf_ff  <= load_ovf_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         tail_ff      <= tail_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      load_last_ff <= load_last_in;
      ent_ff       <= ent_in;
      base_ff      <= base_in;
      idx_ff       <= idx_in;
      cmp_len_ff   <= cmp_len_in;
      src_load_ff  <= src_load_in;
      eot_ff       <= eot_in;
      out_char_ff  <= out_char_in;
      out_pos_ff   <= out_pos_in;
      out_last_ff  <= out_last_in;
      out_trunc_ff <= out_trunc_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_token_char     = out_char_ff;
   assign rsp_token_position = out_pos_ff;
   assign rsp_last_char      = out_last_ff;
   assign rsp_truncated      = out_trunc_ff;

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CP) |-> (count_ff < CW'(MAX_STOP)))
      else $error("stop entry copy with full table");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMITW) |-> (idx_ff < word_len_ff))
      else $error("emit index past word length");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LEN) |-> (ent_ff <= count_ff))
      else $error("table search past stored entries");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("pending result lost while stalled");

endmodule

// ===== sv/text_tokenizer_stop_word_filter_unit.sv =====
// Whitespace tokenizer with a stop-word filter.
// Input channel req_: req_kind selects text byte, end of text, stop-word byte
// or stop-word end; req_data_byte carries the byte. A transaction is taken
// when req_valid is high and req_stall is low.
// Result channel rsp_: one transaction per emitted token character, with the
// token position, a last-character flag and a truncation flag.
// A classifier feeds a two-entry operation queue; an execution sequencer
// drains it. Text and stop-word bytes are taken in the idle state, and the
// sequencer stays idle, ready for the next item. A word end searches the stop
// table entry by entry, comparing the length and, when the lengths agree, each
// character; a word that is not found is emitted character by character, and
// a truncated word is emitted without a search. Storing a new stop word runs
// the same search and then copies its characters into the table.
// While rsp_stall is high a pending result holds and further emission waits;
// the queue keeps accepting until both entries are full.
// Synchronous reset empties the queue, the table and the current word and
// restarts the token position at zero.
module text_tokenizer_stop_word_filter_unit #(
   parameter int unsigned MAX_WORD = 32,
   parameter int unsigned MAX_STOP = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_kind,
   input  logic [7:0]                req_data_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_token_char,
   output logic [tsw_pkg::POS_W-1:0] rsp_token_position,
   output logic                      rsp_last_char,
   output logic                      rsp_truncated
);

   logic            push, pop, q_full, q_valid;
   tsw_pkg::op_type push_op, q_op;

   tsw_front u_front (
      .req_valid(req_valid), .req_kind(req_kind), .req_data_byte(req_data_byte),
      .q_full(q_full), .req_stall(req_stall), .push(push), .push_op(push_op)
   );

   tsw_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_op(push_op), .pop(pop),
      .full(q_full), .q_valid(q_valid), .q_op(q_op)
   );

   tsw_back #(.MAX_WORD(MAX_WORD), .MAX_STOP(MAX_STOP)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_op(q_op), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_token_char(rsp_token_char),
      .rsp_token_position(rsp_token_position), .rsp_last_char(rsp_last_char),
      .rsp_truncated(rsp_truncated)
   );

endmodule

// ===== tb/sv/text_tokenizer_stop_word_filter_unit_test.sv =====
module text_tokenizer_stop_word_filter_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_WORD = 32;
   localparam int unsigned MAX_STOP = 64;
   localparam int unsigned IDLE_LIMIT = 40000;

   typedef struct packed {
      logic [7:0]  chr;
      logic [15:0] pos;
      logic        last;
      logic        trunc;
   } token_char_type;

   // directed row: kind, byte, optional typed-in expectation for a single-char token
   typedef struct packed {
      logic [1:0]     kind;
      logic [7:0]     data;
      logic           has_fixed;
      token_char_type fixed;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_kind = tsw_pkg::KIND_TEXT;
   logic [7:0] req_data_byte = 8'h00;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_token_char;
   logic [tsw_pkg::POS_W-1:0] rsp_token_position;
   logic rsp_last_char;
   logic rsp_truncated;

   // predictor state
   logic [7:0]  cur_word [MAX_WORD];
   int unsigned cur_len;
   logic        cur_over;
   logic [15:0] tok_pos;
   logic [7:0]  stop_tab [MAX_STOP][MAX_WORD];
   int unsigned stop_len [MAX_STOP];
   int unsigned stop_num;
   logic [7:0]  ld_word [MAX_WORD];
   int unsigned ld_len;
   logic        ld_over;

   token_char_type expected_chars [$];
   int unsigned error_count = 0;
   int unsigned idle_cycles = 0;
   bit          hold_rsp = 1'b0;

   text_tokenizer_stop_word_filter_unit #(
      .MAX_WORD(MAX_WORD),
      .MAX_STOP(MAX_STOP)
   ) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_kind(req_kind), .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_token_char(rsp_token_char), .rsp_token_position(rsp_token_position),
      .rsp_last_char(rsp_last_char), .rsp_truncated(rsp_truncated)
   );

   // clock generation
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= "A" && c <= "Z") begin
         r = c + 8'd32;
      end
      return r;
   endfunction

   function automatic bit is_space(input logic [7:0] c);
      return c == " " || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic bit is_kept(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
             (c >= "0" && c <= "9") || c == tsw_pkg::CHAR_DASH;
   endfunction

   function automatic bit word_in_stops(input logic [7:0] w [MAX_WORD],
                                        input int unsigned n);
      bit same;
      for (int e = 0; e < stop_num; e++) begin
         if (stop_len[e] == n) begin
            same = 1'b1;
            for (int i = 0; i < n; i++) begin
               if (stop_tab[e][i] != w[i]) same = 1'b0;
            end
            if (same) return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void flush_word();
      token_char_type t;
      if (cur_len > 0 && (cur_over || !word_in_stops(cur_word, cur_len))) begin
         for (int i = 0; i < cur_len; i++) begin
            t.chr = cur_word[i];
            t.pos = tok_pos;
            t.last = (i + 1 == cur_len);
            t.trunc = cur_over;
            expected_chars.push_back(t);
         end
         if (tok_pos != 16'hFFFF) tok_pos++;
      end
      cur_len = 0;
      cur_over = 1'b0;
   endfunction

   function automatic void store_stop_word();
      int unsigned n;
      n = ld_len;
      if (!ld_over && n > 0 && ld_word[n-1] == tsw_pkg::CHAR_CR) n--;
      if (!ld_over && n > 0 && stop_num < MAX_STOP && !word_in_stops(ld_word, n)) begin
         for (int i = 0; i < n; i++) stop_tab[stop_num][i] = ld_word[i];
         stop_len[stop_num] = n;
         stop_num++;
      end
      ld_len = 0;
      ld_over = 1'b0;
   endfunction

   function automatic void predict_tokens(input logic [1:0] kind, input logic [7:0] b);
      case (kind)
         tsw_pkg::KIND_TEXT: begin
            if (is_space(b)) begin
               flush_word();
            end else if (b < 8'd128 && is_kept(b)) begin
               if (cur_len < MAX_WORD) begin
                  cur_word[cur_len] = to_lower(b);
                  cur_len++;
               end else cur_over = 1'b1;
            end
         end
         tsw_pkg::KIND_END_TEXT: begin
            flush_word();
            tok_pos = 16'd0;
         end
         tsw_pkg::KIND_STOP: begin
            if (ld_len < MAX_WORD) begin
               ld_word[ld_len] = to_lower(b);
               ld_len++;
            end else ld_over = 1'b1;
         end
         default: store_stop_word();
      endcase
   endfunction

   // one input transaction, then an optional gap of the given length
   task automatic send_item(input logic [1:0] kind, input logic [7:0] b, input int gap);
      req_kind <= kind;
      req_data_byte <= b;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_tokens(kind, b);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic int draw_gap();
      return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
   endfunction

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(tsw_pkg::KIND_TEXT, s[i], draw_gap());
   endtask

   task automatic send_stop(input string s);
      for (int i = 0; i < s.len(); i++) send_item(tsw_pkg::KIND_STOP, s[i], draw_gap());
      send_item(tsw_pkg::KIND_STOP_END, 8'h00, draw_gap());
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   function automatic logic [7:0] random_word_char();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 5) return 8'(8'h61 + $urandom_range(0, 4));
      if (r < 7) return 8'(8'h41 + $urandom_range(0, 4));
      if (r == 7) return 8'(8'h30 + $urandom_range(0, 9));
      if (r == 8) return tsw_pkg::CHAR_DASH;
      return 8'($urandom_range(0, 255));
   endfunction

   // result checking
   always @(posedge clock) begin
      token_char_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            report_mismatch("unexpected result", {8'h00, rsp_token_char}, 16'h0);
         end else begin
            want = expected_chars.pop_front();
            if (rsp_token_char !== want.chr)
               report_mismatch("token_char", {8'h00, rsp_token_char}, {8'h00, want.chr});
            if (rsp_token_position !== want.pos)
               report_mismatch("token_position", rsp_token_position, want.pos);
            if (rsp_last_char !== want.last)
               report_mismatch("last_char", {15'd0, rsp_last_char}, {15'd0, want.last});
            if (rsp_truncated !== want.trunc)
               report_mismatch("truncated", {15'd0, rsp_truncated}, {15'd0, want.trunc});
         end
      end
   end

   // receiver stalls
   initial begin
      int w;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 1) == 0) begin
            rsp_stall <= 1'b0;
         end else begin
            w = $urandom_range(0, 11);
            if (w != 0) begin
               rsp_stall <= 1'b1;
               repeat (w) @(negedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("text_tokenizer_stop_word_filter_unit_test NOT OK");
         $finish;
      end
   end

   initial begin
      stim_row_type rows [$];
      stim_row_type r;
      int n_items;
      int gap;
      cur_len = 0; cur_over = 0; tok_pos = 0; stop_num = 0; ld_len = 0; ld_over = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table: single-character tokens carry their fixed expectation
      rows.push_back('{tsw_pkg::KIND_TEXT, "Z", 1'b0, '0});
      rows.push_back('{tsw_pkg::KIND_TEXT, " ", 1'b1, '{"z", 16'd0, 1'b1, 1'b0}});
      rows.push_back('{tsw_pkg::KIND_TEXT, 8'hFF, 1'b0, '0});
      rows.push_back('{tsw_pkg::KIND_TEXT, "0", 1'b0, '0});
      rows.push_back('{tsw_pkg::KIND_TEXT, 8'h80, 1'b0, '0});
      rows.push_back('{tsw_pkg::KIND_TEXT, 8'h09, 1'b1, '{"0", 16'd1, 1'b1, 1'b0}});
      rows.push_back('{tsw_pkg::KIND_TEXT, "!", 1'b0, '0});
      rows.push_back('{tsw_pkg::KIND_TEXT, 8'h00, 1'b0, '0});
      rows.push_back('{tsw_pkg::KIND_TEXT, 8'h0D, 1'b0, '0});
      rows.push_back('{tsw_pkg::KIND_TEXT, "-", 1'b0, '0});
      rows.push_back('{tsw_pkg::KIND_END_TEXT, 8'hFF, 1'b1, '{"-", 16'd2, 1'b1, 1'b0}});
      rows.push_back('{tsw_pkg::KIND_END_TEXT, 8'h00, 1'b0, '0});
      rows.push_back('{tsw_pkg::KIND_STOP, "A", 1'b0, '0});
      rows.push_back('{tsw_pkg::KIND_STOP, 8'h0D, 1'b0, '0});
      rows.push_back('{tsw_pkg::KIND_STOP_END, 8'h00, 1'b0, '0});
      rows.push_back('{tsw_pkg::KIND_TEXT, "a", 1'b0, '0});
      rows.push_back('{tsw_pkg::KIND_TEXT, " ", 1'b0, '0});
      rows.push_back('{tsw_pkg::KIND_TEXT, "b", 1'b0, '0});
      rows.push_back('{tsw_pkg::KIND_TEXT, 8'h0C, 1'b1, '{"b", 16'd0, 1'b1, 1'b0}});
      rows.push_back('{tsw_pkg::KIND_STOP_END, 8'h00, 1'b0, '0});
      foreach (rows[i]) begin
         r = rows[i];
         if (r.has_fixed) begin
            // the predictor is checked too: the typed-in value must match it
            predict_tokens(r.kind, r.data);
            if (expected_chars.size() == 0 || expected_chars[$] != r.fixed)
               report_mismatch("directed table", 16'h0, 16'h1);
            req_kind <= r.kind;
            req_data_byte <= r.data;
            req_valid <= 1'b1;
            do @(posedge clock); while (req_stall);
            @(negedge clock);
            gap = draw_gap();
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end else begin
            send_item(r.kind, r.data, draw_gap());
         end
      end
      // long word, truncated and never filtered; long stop word dropped
      send_text("abcdefghijklmnopqrstuvwxyz0123456789 ");
      send_stop("abcdefghijklmnopqrstuvwxyz0123456789");
      send_stop("The");
      send_stop("the");
      send_stop("");
      send_text("THE the thee ");
      wait_drained();

      // receiver holds off while the sender keeps offering
      hold_rsp = 1'b1;
      for (int i = 0; i < 40; i++)
         send_item(tsw_pkg::KIND_TEXT, (i % 4 == 3) ? " " : "q", 0);
      wait_drained();

      // random part: mostly well-formed words, some stop-word loads and noise
      n_items = 0;
      while (n_items < 80) begin
         int unsigned sel;
         int unsigned len;
         sel = $urandom_range(0, 19);
         len = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 4);
         if (sel < 2) begin
            for (int i = 0; i < len; i++)
               send_item(tsw_pkg::KIND_STOP, random_word_char(), draw_gap());
            if ($urandom_range(0, 3) == 0)
               send_item(tsw_pkg::KIND_STOP, tsw_pkg::CHAR_CR, draw_gap());
            send_item(tsw_pkg::KIND_STOP_END, 8'($urandom_range(0, 255)), draw_gap());
            n_items += len + 1;
         end else if (sel == 2) begin
            send_item(tsw_pkg::KIND_END_TEXT, 8'($urandom_range(0, 255)), draw_gap());
            n_items++;
         end else if (sel == 3) begin
            send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), draw_gap());
            n_items++;
         end else begin
            for (int i = 0; i < len; i++)
               send_item(tsw_pkg::KIND_TEXT, random_word_char(), draw_gap());
            send_item(tsw_pkg::KIND_TEXT, ($urandom_range(0, 1) != 0) ? tsw_pkg::CHAR_SPACE :
                      8'(8'h09 + $urandom_range(0, 4)), draw_gap());
            n_items += len + 1;
         end
         if (n_items > 35 && n_items < 45) begin
            wait_drained();
            n_items = 45;
         end
      end
      // fill the stop table past its capacity, then check it is still honored
      for (int i = 0; i < MAX_STOP + 2; i++) begin
         send_item(tsw_pkg::KIND_STOP, 8'(8'h80 + i), 0);
         send_item(tsw_pkg::KIND_STOP_END, 8'h00, 0);
      end
      send_stop("zzz");
      send_text("a the zzz x ");
      send_item(tsw_pkg::KIND_END_TEXT, 8'h00, 0);

      wait_drained();
      if (error_count == 0 && expected_chars.size() == 0) begin
         $display("text_tokenizer_stop_word_filter_unit_test OK");
      end else begin
         $display("text_tokenizer_stop_word_filter_unit_test NOT OK");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/tsw_pkg.sv
sv/tsw_ram.sv
sv/tsw_front.sv
sv/tsw_queue.sv
sv/tsw_back.sv
sv/text_tokenizer_stop_word_filter_unit.sv
tb/sv/text_tokenizer_stop_word_filter_unit_test.sv
